[src/gha_pkg.sv]
// Shared types and constants for the generational handle allocator.
// Used by gha_free_stack and generational_handle_allocator; no dependencies.
`default_nettype none

package gha_pkg;

    localparam int SLOT_INDEX_BITS = 10;
    localparam int GENERATION_BITS = 21;
    localparam int SLOT_CAPACITY   = 1024;
    localparam int COUNT_W         = SLOT_INDEX_BITS + 1;
    localparam int TAG_W           = 32;
    localparam int HANDLE_W        = 32;
    localparam int STATUS_W        = 3;
    localparam int REF_BIT         = SLOT_INDEX_BITS + GENERATION_BITS;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 48;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TAG   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STALE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd5;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic                       refflag;
        logic [GENERATION_BITS-1:0] generation;
        logic [TAG_W-1:0]           owner;
    } slot_entry_t;

    typedef struct packed {
        logic                       rd_en;
        logic [SLOT_INDEX_BITS-1:0] rd_addr;
        logic                       wr_en;
        logic [SLOT_INDEX_BITS-1:0] wr_addr;
        logic [SLOT_INDEX_BITS-1:0] wr_data;
    } fs_req_t;

endpackage

`default_nettype wire

[src/gha_free_stack.sv]
// Free slot stack: one synchronous memory with a registered read.
// Entries at or above the write mark were never written and read as their own index.
// Depends on gha_pkg.
`default_nettype none

module gha_free_stack
    import gha_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire fs_req_t                    req,
    output logic [SLOT_INDEX_BITS-1:0]      rd_data
);

    logic [SLOT_INDEX_BITS-1:0] mem [SLOT_CAPACITY];
    logic [SLOT_INDEX_BITS-1:0] mem_q_reg;
    logic [SLOT_INDEX_BITS-1:0] addr_q_reg;
    logic                       fresh_reg;
    logic [COUNT_W-1:0]         mark_reg;
    logic [COUNT_W-1:0]         mark_next;
    logic [COUNT_W-1:0]         wr_top;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            mem_q_reg  <= mem[req.rd_addr];
            addr_q_reg <= req.rd_addr;
            fresh_reg  <= COUNT_W'(req.rd_addr) >= mark_reg;
        end
    end

    // Every index below the mark has been written before any read reaches it.
    always_comb begin
        wr_top    = COUNT_W'(req.wr_addr) + COUNT_W'(1);
        mark_next = mark_reg;
        if (req.wr_en && wr_top > mark_reg) begin
            mark_next = wr_top;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_reg <= '0;
        end else begin
            mark_reg <= mark_next;
        end
    end

    assign rd_data = fresh_reg ? addr_q_reg : mem_q_reg;

endmodule

`default_nettype wire

[src/generational_handle_allocator.sv]
// Generational handle allocator: handle table on a free stack and a slot memory.
// Depends on gha_pkg and gha_free_stack.
//
// After reset the block sweeps the slot memory to zero, one slot a cycle, and
// holds s_tready low meanwhile. A release reads the slot memory, then checks
// and writes back; an allocate reads the free stack first, since the slot index
// comes from that read, which must finish before the slot memory read.
// Each item gives exactly one result transfer; the result sits in an output
// register, so the next item is taken while it waits, and an item only stalls
// in its last cycle if the previous result has not been taken.
`default_nettype none

module generational_handle_allocator
    import gha_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // object_tag[31:0], ref_flag[32], handle_in[64:33], zero fill
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // op[0]
    input  wire logic [0:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // status[2:0], handle_out[34:3], live_count[45:35], zero fill
    output logic [M_TDATA_W-1:0]       m_tdata
);

    state_t                     state_reg, state_next;
    logic [SLOT_INDEX_BITS-1:0] clr_idx_reg, clr_idx_next;
    logic [COUNT_W-1:0]         used_count_reg, used_count_next;
    logic [GENERATION_BITS-1:0] gen_counter_reg, gen_counter_next;
    logic                       m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]       m_tdata_reg, m_tdata_next;

    // item registers
    logic                       op_reg, op_next;
    logic [TAG_W-1:0]           tag_reg, tag_next;
    logic                       ref_reg, ref_next;
    logic [SLOT_INDEX_BITS-1:0] slot_reg, slot_next;
    logic [GENERATION_BITS-1:0] hgen_reg, hgen_next;

    // slot memory
    slot_entry_t                slot_mem [SLOT_CAPACITY];
    slot_entry_t                slot_q_reg;
    logic                       slot_re;
    logic [SLOT_INDEX_BITS-1:0] slot_raddr;
    logic                       slot_we;
    logic [SLOT_INDEX_BITS-1:0] slot_waddr;
    slot_entry_t                slot_wdata;

    fs_req_t                    fs_req;
    logic [SLOT_INDEX_BITS-1:0] fs_rd_data;

    logic [TAG_W-1:0]           in_tag;
    logic                       in_ref;
    logic [HANDLE_W-1:0]        in_handle;
    logic                       out_free;
    logic [GENERATION_BITS-1:0] gen_inc;
    logic [GENERATION_BITS-1:0] gen_new;
    logic [COUNT_W-1:0]         cnt_inc;
    logic [COUNT_W-1:0]         cnt_dec;
    logic [STATUS_W-1:0]        res_status;
    logic [HANDLE_W-1:0]        res_handle;

    gha_free_stack u_free_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fs_req),
        .rd_data (fs_rd_data)
    );

    assign in_tag    = s_tdata[TAG_W-1:0];
    assign in_ref    = s_tdata[TAG_W];
    assign in_handle = s_tdata[TAG_W+1 +: HANDLE_W];

    assign out_free = !m_valid_reg || m_tready;
    assign gen_inc  = gen_counter_reg + GENERATION_BITS'(1);
    assign gen_new  = (gen_inc == '0) ? GENERATION_BITS'(1) : gen_inc;
    assign cnt_inc  = used_count_reg + COUNT_W'(1);
    assign cnt_dec  = used_count_reg - COUNT_W'(1);

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (slot_re) begin
            slot_q_reg <= slot_mem[slot_raddr];
        end
    end

    always_comb begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        used_count_next  = used_count_reg;
        gen_counter_next = gen_counter_reg;
        m_valid_next     = m_valid_reg;
        m_tdata_next     = m_tdata_reg;
        op_next          = op_reg;
        tag_next         = tag_reg;
        ref_next         = ref_reg;
        slot_next        = slot_reg;
        hgen_next        = hgen_reg;
        s_tready         = 1'b0;
        slot_re          = 1'b0;
        slot_raddr       = slot_reg;
        slot_we          = 1'b0;
        slot_waddr       = slot_reg;
        slot_wdata       = '0;
        fs_req           = '0;
        res_status       = ST_OK;
        res_handle       = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                slot_we      = 1'b1;
                slot_waddr   = clr_idx_reg;
                clr_idx_next = clr_idx_reg + SLOT_INDEX_BITS'(1);
                if (clr_idx_reg == SLOT_INDEX_BITS'(SLOT_CAPACITY - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next   = s_tuser[0];
                    tag_next  = in_tag;
                    ref_next  = in_ref;
                    slot_next = in_handle[SLOT_INDEX_BITS-1:0];
                    hgen_next = in_handle[SLOT_INDEX_BITS +: GENERATION_BITS];
                    if (s_tuser[0] == OP_ALLOC) begin
                        fs_req.rd_en   = 1'b1;
                        fs_req.rd_addr = used_count_reg[SLOT_INDEX_BITS-1:0];
                        state_next     = S_FETCH;
                    end else begin
                        slot_re    = 1'b1;
                        slot_raddr = in_handle[SLOT_INDEX_BITS-1:0];
                        state_next = S_EXEC;
                    end
                end
            end
            S_FETCH: begin
                slot_re    = 1'b1;
                slot_raddr = fs_rd_data;
                slot_next  = fs_rd_data;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                // hold the item until the output register can take its result
                if (out_free) begin
                    if (op_reg == OP_ALLOC) begin
                        if (used_count_reg >= COUNT_W'(SLOT_CAPACITY)) begin
                            res_status = ST_FULL;
                        end else if (tag_reg == '0) begin
                            res_status = ST_TAG;
                        end else if (COUNT_W'(slot_reg) >= COUNT_W'(SLOT_CAPACITY) ||
                                     slot_q_reg.owner != '0) begin
                            res_status = ST_BUSY;
                        end else begin
                            res_status            = ST_OK;
                            gen_counter_next      = gen_new;
                            used_count_next       = cnt_inc;
                            slot_we               = 1'b1;
                            slot_waddr            = slot_reg;
                            slot_wdata.owner      = tag_reg;
                            slot_wdata.generation = gen_new;
                            slot_wdata.refflag    = ref_reg;
                            res_handle[SLOT_INDEX_BITS-1:0] = slot_reg;
                            res_handle[SLOT_INDEX_BITS +: GENERATION_BITS] = gen_new;
                            res_handle[REF_BIT]   = ref_reg;
                        end
                    end else begin
                        if (used_count_reg == '0) begin
                            res_status = ST_EMPTY;
                        end else if (COUNT_W'(slot_reg) >= COUNT_W'(SLOT_CAPACITY) ||
                                     slot_q_reg.owner == '0 ||
                                     slot_q_reg.owner != tag_reg) begin
                            res_status = ST_TAG;
                        end else if (slot_q_reg.generation != hgen_reg) begin
                            res_status = ST_STALE;
                        end else begin
                            res_status      = ST_OK;
                            used_count_next = cnt_dec;
                            fs_req.wr_en    = 1'b1;
                            fs_req.wr_addr  = cnt_dec[SLOT_INDEX_BITS-1:0];
                            fs_req.wr_data  = slot_reg;
                            slot_we         = 1'b1;
                            slot_waddr      = slot_reg;
                            slot_wdata      = '0;
                        end
                    end
                    m_valid_next = 1'b1;
                    m_tdata_next = '0;
                    m_tdata_next[STATUS_W-1:0]           = res_status;
                    m_tdata_next[STATUS_W +: HANDLE_W]   = res_handle;
                    m_tdata_next[STATUS_W + HANDLE_W +: COUNT_W] = used_count_next;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            clr_idx_reg     <= '0;
            used_count_reg  <= '0;
            gen_counter_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            clr_idx_reg     <= clr_idx_next;
            used_count_reg  <= used_count_next;
            gen_counter_reg <= gen_counter_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        op_reg      <= op_next;
        tag_reg     <= tag_next;
        ref_reg     <= ref_next;
        slot_reg    <= slot_next;
        hgen_reg    <= hgen_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

[dv/generational_handle_allocator_tb.sv]
// Testbench for generational_handle_allocator: predicts every result from its own model of
// the handle table and checks each m_ transfer in order.
// Depends on gha_pkg and the allocator RTL only.
`default_nettype none

module generational_handle_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gha_pkg::*;

    localparam int CLK_PERIOD  = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic [COUNT_W-1:0]  live;
    } result_t;

    typedef enum int {
        NZ_ZERO_TAG,
        NZ_WRONG_TAG,
        NZ_STALE_GEN,
        NZ_RANDOM_HANDLE
    } noise_kind_e;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    // Handle table model
    logic [SLOT_INDEX_BITS-1:0] free_slots [SLOT_CAPACITY];
    logic [TAG_W-1:0]           owner_of   [SLOT_CAPACITY];
    logic [GENERATION_BITS-1:0] gen_of     [SLOT_CAPACITY];
    logic [COUNT_W-1:0]         used_slots;
    logic [GENERATION_BITS-1:0] gen_ctr;
    logic [SLOT_INDEX_BITS-1:0] live_slots [$];

    result_t     pending_results [$];
    result_t     last_result;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_idle_pct  = 0;
    int unsigned hold_request = 0;

    generational_handle_allocator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic result_t predict_table_op(input logic op, input logic [TAG_W-1:0] tag,
                                                 input logic refc,
                                                 input logic [HANDLE_W-1:0] hin);
        result_t                    r;
        logic [SLOT_INDEX_BITS-1:0] slot;
        logic [GENERATION_BITS-1:0] gen;
        r = '0;
        r.status = ST_OK;
        if (op == OP_ALLOC) begin
            if (used_slots >= SLOT_CAPACITY) begin
                r.status = ST_FULL;
            end else if (tag == '0) begin
                r.status = ST_TAG;
            end else begin
                slot = free_slots[used_slots];
                if (owner_of[slot] != '0) begin
                    r.status = ST_BUSY;
                end else begin
                    gen = gen_ctr + 1'b1;
                    // skip zero when the generation wraps
                    if (gen == '0)
                        gen = GENERATION_BITS'(1);
                    gen_ctr = gen;
                    owner_of[slot] = tag;
                    gen_of[slot] = gen;
                    used_slots++;
                    live_slots.push_back(slot);
                    r.handle = {refc, gen, slot};
                end
            end
        end else begin
            slot = hin[SLOT_INDEX_BITS-1:0];
            gen = hin[REF_BIT-1:SLOT_INDEX_BITS];
            if (used_slots == '0) begin
                r.status = ST_EMPTY;
            end else if (owner_of[slot] == '0 || owner_of[slot] != tag) begin
                r.status = ST_TAG;
            end else if (gen_of[slot] != gen) begin
                r.status = ST_STALE;
            end else begin
                used_slots--;
                free_slots[used_slots] = slot;
                owner_of[slot] = '0;
                gen_of[slot] = '0;
                for (int i = 0; i < live_slots.size(); i++) begin
                    if (live_slots[i] == slot) begin
                        live_slots.delete(i);
                        break;
                    end
                end
            end
        end
        r.live = used_slots;
        return r;
    endfunction

    function automatic logic [TAG_W-1:0] random_tag();
        logic [TAG_W-1:0] t;
        do
            t = $urandom;
        while (t == '0);
        return t;
    endfunction

    // Drive one item, hold it until the transfer, then maybe idle.
    task automatic send_item(input logic op, input logic [TAG_W-1:0] tag, input logic refc,
                             input logic [HANDLE_W-1:0] hin);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - TAG_W - HANDLE_W - 1){1'b0}}, hin, refc, tag};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        last_result = predict_table_op(op, tag, refc, hin);
        pending_results.push_back(last_result);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15))
                @(posedge aclk);
        end
    endtask

    task automatic send_random_op(input int unsigned alloc_pct);
        int unsigned                pick;
        noise_kind_e                kind;
        logic [SLOT_INDEX_BITS-1:0] slot;
        logic [TAG_W-1:0]           tag_x;
        logic [GENERATION_BITS-1:0] gen_x;
        logic                       refc;
        pick = $urandom_range(0, 99);
        refc = 1'($urandom_range(0, 1));
        slot = '0;
        if (live_slots.size() != 0)
            slot = live_slots[$urandom_range(0, live_slots.size() - 1)];
        if (pick < alloc_pct) begin
            send_item(OP_ALLOC, random_tag(), refc, $urandom);
        end else if (pick < alloc_pct + 10 || live_slots.size() == 0) begin
            kind = noise_kind_e'($urandom_range(0, 3));
            if (live_slots.size() == 0 && (kind == NZ_WRONG_TAG || kind == NZ_STALE_GEN))
                kind = NZ_RANDOM_HANDLE;
            tag_x = random_tag();
            gen_x = GENERATION_BITS'($urandom_range(1, (1 << GENERATION_BITS) - 1));
            case (kind)
                NZ_ZERO_TAG: begin
                    send_item(OP_ALLOC, '0, refc, $urandom);
                end
                NZ_WRONG_TAG: begin
                    send_item(OP_RELEASE, owner_of[slot] ^ tag_x, refc,
                              {refc, gen_of[slot], slot});
                end
                NZ_STALE_GEN: begin
                    send_item(OP_RELEASE, owner_of[slot], refc,
                              {refc, gen_of[slot] ^ gen_x, slot});
                end
                default: begin
                    send_item(OP_RELEASE, $urandom, refc, $urandom);
                end
            endcase
        end else begin
            send_item(OP_RELEASE, owner_of[slot], 1'($urandom_range(0, 1)),
                      {refc, gen_of[slot], slot});
        end
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_directed_cases();
        logic [HANDLE_W-1:0] h0;
        logic [HANDLE_W-1:0] h1;
        logic [HANDLE_W-1:0] h2;
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        send_item(OP_RELEASE, random_tag(), 1'b1, $urandom);
        send_item(OP_ALLOC, '0, 1'b1, '0);
        send_item(OP_ALLOC, '1, 1'b1, '1);
        h0 = last_result.handle;
        send_item(OP_ALLOC, 32'd1, 1'b0, '0);
        h1 = last_result.handle;
        send_item(OP_ALLOC, 32'h8000_0000, 1'b1, 32'h5555_5555);
        h2 = last_result.handle;
        send_item(OP_RELEASE, 32'hFFFF_FFFE, 1'b0, h0);
        send_item(OP_RELEASE, 32'd1, 1'b0, h1 ^ (HANDLE_W'(1) << SLOT_INDEX_BITS));
        // slot never handed out
        send_item(OP_RELEASE, 32'd5, 1'b0, 32'h0000_0FFF);
        send_item(OP_RELEASE, '0, 1'b1, h2);
        // reference bit of the handle must not matter on release
        send_item(OP_RELEASE, 32'd1, 1'b1, h1 | (HANDLE_W'(1) << REF_BIT));
        send_item(OP_RELEASE, 32'd1, 1'b0, h1);
        // same slot comes back off the stack with a newer generation
        send_item(OP_ALLOC, 32'd1, 1'b0, $urandom);
        send_item(OP_RELEASE, 32'd1, 1'b0, h1);
        h1 = last_result.handle;
        send_item(OP_RELEASE, '1, 1'b0, '1);
        send_item(OP_RELEASE, '1, 1'b0, h0);
        send_item(OP_RELEASE, 32'h8000_0000, 1'b0, h2);
        send_item(OP_RELEASE, 32'd1, 1'b0, {1'b0, gen_of[1], SLOT_INDEX_BITS'(1)});
        send_item(OP_RELEASE, 32'd1, 1'b0, h1);
        send_item(OP_ALLOC, random_tag(), 1'b1, $urandom);
    endtask

    task automatic test_random_mix();
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        repeat (30)
            send_random_op(50);
    endtask

    task automatic test_output_backpressure();
        tx_idle_pct = 0;
        hold_request = 300;
        repeat (30)
            send_random_op(50);
        wait_for_results();
    endtask

    task automatic test_fill_to_capacity();
        int unsigned n;
        n = 0;
        while (used_slots < SLOT_CAPACITY && n < 4000) begin
            // alternate stretches with and without idling
            tx_idle_pct = ((n / 128) % 2 == 0) ? 10 : 0;
            rx_idle_pct = ((n / 128) % 2 == 0) ? 15 : 0;
            send_random_op(97);
            n++;
        end
        repeat (4)
            send_item(OP_ALLOC, random_tag(), 1'($urandom_range(0, 1)), $urandom);
        repeat (8)
            send_random_op(50);
    endtask

    task automatic test_drain();
        tx_idle_pct = 15;
        rx_idle_pct = 15;
        repeat (30)
            send_random_op(10);
    endtask

    task automatic test_tail_no_idle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (30)
            send_random_op(45);
    endtask

    // Result sink: random stall bursts, plus one long hold-off on request.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request != 0) begin
                m_tready <= 1'b0;
                repeat (hold_request)
                    @(posedge aclk);
                hold_request = 0;
            end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15))
                    @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[2:0];
            got.handle = m_tdata[34:3];
            got.live   = m_tdata[45:35];
            if (pending_results.size() == 0) begin
                if (error_count < MAX_REPORTS)
                    $display("cycle %0d: result transfer with nothing pending: %h",
                             cycle_count, m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status || got.handle != want.handle ||
                    got.live != want.live) begin
                    if (error_count < MAX_REPORTS) begin
                        $display("cycle %0d: mismatch exp status %0d handle %h live %0d",
                                 cycle_count, want.status, want.handle, want.live);
                        $display("    got status %0d handle %h live %0d",
                                 got.status, got.handle, got.live);
                    end
                    error_count++;
                end
            end
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= '0;
        s_tdata  <= '0;
        for (int i = 0; i < SLOT_CAPACITY; i++) begin
            free_slots[i] = SLOT_INDEX_BITS'(i);
            owner_of[i] = '0;
            gen_of[i] = '0;
        end
        used_slots = '0;
        gen_ctr = '0;
        repeat (3)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_random_mix();
        test_output_backpressure();
        test_fill_to_capacity();
        test_drain();
        test_tail_no_idle();

        wait_for_results();
        repeat (16)
            @(posedge aclk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
src/gha_pkg.sv
src/gha_free_stack.sv
src/generational_handle_allocator.sv
dv/generational_handle_allocator_tb.sv
